/* rtl/core/mi3_pkg.sv */
// Shared types and constants for the 3x3 matrix inverse pipeline.
// Holds the request and result structs and the divider lane record.
// No dependencies.
package mi3_pkg;

  // Determinant magnitude width; |det| stays below 3 * 2^94.
  localparam int DW  = 97;
  // Signed determinant accumulator width.
  localparam int DSW = 98;
  // Quotient bits produced by the divider before rounding.
  localparam int QW  = 33;

  typedef struct packed {
    logic signed [31:0] in_r0c0;
    logic signed [31:0] in_r0c1;
    logic signed [31:0] in_r0c2;
    logic signed [31:0] in_r1c0;
    logic signed [31:0] in_r1c1;
    logic signed [31:0] in_r1c2;
    logic signed [31:0] in_r2c0;
    logic signed [31:0] in_r2c1;
    logic signed [31:0] in_r2c2;
  } mi3_in_t;

  typedef struct packed {
    logic signed [31:0] out_r0c0;
    logic signed [31:0] out_r0c1;
    logic signed [31:0] out_r0c2;
    logic signed [31:0] out_r1c0;
    logic signed [31:0] out_r1c1;
    logic signed [31:0] out_r1c2;
    logic signed [31:0] out_r2c0;
    logic signed [31:0] out_r2c1;
    logic signed [31:0] out_r2c2;
    logic               singular;
    logic               saturated;
  } mi3_out_t;

  // Determinant summary handed from the determinant stages to the divider.
  typedef struct packed {
    logic [DW-1:0] dmag;
    logic          dneg;
    logic          singular;
  } mi3_det_t;

  // One divider lane: partial remainder, quotient so far and flags.
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] quo;
    logic          neg;
    logic          ovf;
    logic          lsb;
  } mi3_lane_t;

endpackage

/* rtl/core/mi3_cofactor.sv */
// Cofactor stages: eighteen 32x32 products, then nine Q32.32 cofactors.
// Depends on mi3_pkg.
module mi3_cofactor
  import mi3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  mi3_in_t            m_i,
  output logic               v_o,
  output logic signed [63:0] cof_o [9],
  output logic signed [31:0] a_o [3]
);

  logic signed [31:0] a [3];
  logic signed [31:0] b [3];
  logic signed [31:0] c [3];

  logic signed [63:0] pp_nxt [9][2];
  logic signed [63:0] pp_r   [9][2];
  logic signed [31:0] a1_r   [3];
  logic               v1_r;
  logic signed [63:0] cof_nxt [9];
  logic signed [63:0] cof_r   [9];
  logic signed [31:0] a2_r    [3];
  logic               v2_r;

  // Columns of the incoming matrix.
  assign a[0] = m_i.in_r0c0;
  assign a[1] = m_i.in_r1c0;
  assign a[2] = m_i.in_r2c0;
  assign b[0] = m_i.in_r0c1;
  assign b[1] = m_i.in_r1c1;
  assign b[2] = m_i.in_r2c1;
  assign c[0] = m_i.in_r0c2;
  assign c[1] = m_i.in_r1c2;
  assign c[2] = m_i.in_r2c2;

  // Cross product terms: rows b x c, c x a and a x b.
  always_comb begin
    pp_nxt[0][0] = b[1] * c[2];
    pp_nxt[0][1] = b[2] * c[1];
    pp_nxt[1][0] = b[2] * c[0];
    pp_nxt[1][1] = b[0] * c[2];
    pp_nxt[2][0] = b[0] * c[1];
    pp_nxt[2][1] = b[1] * c[0];
    pp_nxt[3][0] = c[1] * a[2];
    pp_nxt[3][1] = c[2] * a[1];
    pp_nxt[4][0] = c[2] * a[0];
    pp_nxt[4][1] = c[0] * a[2];
    pp_nxt[5][0] = c[0] * a[1];
    pp_nxt[5][1] = c[1] * a[0];
    pp_nxt[6][0] = a[1] * b[2];
    pp_nxt[6][1] = a[2] * b[1];
    pp_nxt[7][0] = a[2] * b[0];
    pp_nxt[7][1] = a[0] * b[2];
    pp_nxt[8][0] = a[0] * b[1];
    pp_nxt[8][1] = a[1] * b[0];
  end

  // Each cofactor is the difference of its two products.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cof_nxt[k] = pp_r[k][0] - pp_r[k][1];
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_r  <= pp_nxt;
      a1_r  <= a;
      cof_r <= cof_nxt;
      a2_r  <= a1_r;
    end
  end

  assign v_o   = v2_r;
  assign cof_o = cof_r;
  assign a_o   = a2_r;

endmodule

/* rtl/core/mi3_det.sv */
// Determinant stages: a . (b x c) from split partial products, then sign
// and magnitude. Cofactors ride along. Depends on mi3_pkg.
module mi3_det
  import mi3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  logic signed [63:0] cof_i [9],
  input  logic signed [31:0] a_i [3],
  output logic               v_o,
  output logic signed [63:0] cof_o [9],
  output mi3_det_t           det_o
);

  logic signed [64:0]  pl_nxt [3];
  logic signed [63:0]  ph_nxt [3];
  logic signed [64:0]  pl_r   [3];
  logic signed [63:0]  ph_r   [3];
  logic [DSW-1:0]      det_nxt;
  logic [DSW-1:0]      det_r;
  logic [DSW-1:0]      dneg_val;
  mi3_det_t            dsum_nxt;
  mi3_det_t            dsum_r;
  logic signed [63:0]  c3_r [9];
  logic signed [63:0]  c4_r [9];
  logic signed [63:0]  c5_r [9];
  logic                v3_r;
  logic                v4_r;
  logic                v5_r;

  // Low and high halves of each row-0 cofactor times its a entry.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pl_nxt[i] = a_i[i] * $signed({1'b0, cof_i[i][31:0]});
      ph_nxt[i] = a_i[i] * $signed(cof_i[i][63:32]);
    end
  end

  // Recombine the halves and sum the three terms.
  always_comb begin
    det_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      det_nxt = det_nxt
              + {{(DSW-96){ph_r[i][63]}}, ph_r[i], 32'b0}
              + {{(DSW-65){pl_r[i][64]}}, pl_r[i]};
    end
  end

  // Sign, magnitude and zero test.
  always_comb begin
    dneg_val          = '0 - det_r;
    dsum_nxt.dneg     = det_r[DSW-1];
    dsum_nxt.dmag     = det_r[DSW-1] ? dneg_val[DW-1:0] : det_r[DW-1:0];
    dsum_nxt.singular = (det_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= v_i;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      det_r  <= det_nxt;
      dsum_r <= dsum_nxt;
      c3_r   <= cof_i;
      c4_r   <= c3_r;
      c5_r   <= c4_r;
    end
  end

  assign v_o   = v5_r;
  assign cof_o = c5_r;
  assign det_o = dsum_r;

endmodule

/* rtl/core/mi3_div.sv */
// Pipelined restoring divider: nine lanes of cofactor * 2^32 / |det|,
// one quotient bit per stage, then rounding, saturation and sign.
// Depends on mi3_pkg.
module mi3_div
  import mi3_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  logic signed [63:0] cof_i [9],
  input  mi3_det_t           det_i,
  output logic               v_o,
  output mi3_out_t           res_o
);

  mi3_lane_t      ln_r [QW+1][9];
  logic [DW-1:0]  d_r  [QW+1];
  logic           sg_r [QW+1];
  logic           v_r  [QW+1];
  mi3_lane_t      prep_nxt [9];
  logic [63:0]    cm [9];
  logic [31:0]    ent [9];
  logic [8:0]     sat_e;
  mi3_out_t       res_nxt;
  mi3_out_t       res_r;
  logic           vo_r;

  // Prepare lanes: magnitude, result sign, overflow test, first remainder.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cm[k] = cof_i[k][63] ? (64'd0 - cof_i[k]) : cof_i[k];
      prep_nxt[k].neg = (cof_i[k][63] ^ det_i.dneg) && (cof_i[k] != '0);
      prep_nxt[k].ovf = {{(DW-63){1'b0}}, cm[k]} >= {det_i.dmag, 1'b0};
      prep_nxt[k].rem = {{(DW-63){1'b0}}, cm[k][63:1]};
      prep_nxt[k].quo = '0;
      prep_nxt[k].lsb = cm[k][0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_r[0] <= prep_nxt;
      d_r[0]  <= det_i.dmag;
      sg_r[0] <= det_i.singular;
    end
  end

  // One quotient bit per stage for every lane.
  for (genvar s = 1; s <= QW; s++) begin : g_step
    mi3_lane_t nx [9];

    always_comb begin
      for (int k = 0; k < 9; k++) begin : l_lane
        logic [DW:0] sh;
        logic        qb;
        sh = {ln_r[s-1][k].rem, (s == 1) ? ln_r[s-1][k].lsb : 1'b0};
        qb = (sh >= {1'b0, d_r[s-1]});
        nx[k]     = ln_r[s-1][k];
        nx[k].rem = qb ? DW'(sh - {1'b0, d_r[s-1]}) : sh[DW-1:0];
        nx[k].quo = {ln_r[s-1][k].quo[QW-2:0], qb};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ln_r[s] <= nx;
        d_r[s]  <= d_r[s-1];
        sg_r[s] <= sg_r[s-1];
      end
    end
  end

  // Round to nearest, clamp to the Q16.16 range and apply the sign; zero all entries if singular.
  always_comb begin
    for (int k = 0; k < 9; k++) begin : l_fin
      logic          rnd;
      logic [QW:0]   qr;
      logic [QW:0]   lim;
      logic [31:0]   mag;
      rnd = {ln_r[QW][k].rem, 1'b0} >= {1'b0, d_r[QW]};
      qr  = {1'b0, ln_r[QW][k].quo} + (QW+1)'(rnd);
      lim = ln_r[QW][k].neg ? (QW+1)'(32'h8000_0000) : (QW+1)'(32'h7FFF_FFFF);
      sat_e[k] = ln_r[QW][k].ovf || (qr > lim);
      mag = sat_e[k] ? lim[31:0] : qr[31:0];
      ent[k] = sg_r[QW] ? 32'd0 : (ln_r[QW][k].neg ? (32'd0 - mag) : mag);
    end
    res_nxt.out_r0c0  = ent[0];
    res_nxt.out_r0c1  = ent[1];
    res_nxt.out_r0c2  = ent[2];
    res_nxt.out_r1c0  = ent[3];
    res_nxt.out_r1c1  = ent[4];
    res_nxt.out_r1c2  = ent[5];
    res_nxt.out_r2c0  = ent[6];
    res_nxt.out_r2c1  = ent[7];
    res_nxt.out_r2c2  = ent[8];
    res_nxt.singular  = sg_r[QW];
    res_nxt.saturated = !sg_r[QW] && (sat_e != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign v_o   = vo_r;
  assign res_o = res_r;

endmodule

/* rtl/core/matrix3x3_inverse.sv */
// Top level of the 3x3 Q16.16 matrix inverse pipeline.
// Depends on mi3_pkg, mi3_cofactor, mi3_det and mi3_div.
//
// Usage:
//   A request on the in_ channel carries one 3x3 matrix of signed Q16.16
//   entries. The out_ channel returns its inverse in Q16.16, with singular
//   set (and all entries zero) when the determinant is zero, and saturated
//   set when any entry was clamped to the Q16.16 range.
//   From an accepted request to out_valid a matrix passes 2 cofactor stages,
//   3 determinant stages, one divider set-up stage, 33 divider stages (one
//   quotient bit each) and one output stage. The divider length sets the
//   latency. Throughput is one matrix per cycle while the receiver does not
//   stall; every stage holds its own request.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall rises; nothing is lost or repeated.
//   Reset clears all valid bits; no results are pending afterwards.
module matrix3x3_inverse
  import mi3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mi3_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mi3_out_t out_data
);

  logic               en;
  logic               cv;
  logic signed [63:0] cof_c [9];
  logic signed [31:0] a_c [3];
  logic               dv;
  logic signed [63:0] cof_d [9];
  mi3_det_t           det_d;

  // The pipeline moves unless a finished result is held by the receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  mi3_cofactor u_cof (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (in_valid),
    .m_i   (in_data),
    .v_o   (cv),
    .cof_o (cof_c),
    .a_o   (a_c)
  );

  mi3_det u_det (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (cv),
    .cof_i (cof_c),
    .a_i   (a_c),
    .v_o   (dv),
    .cof_o (cof_d),
    .det_o (det_d)
  );

  mi3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (dv),
    .cof_i (cof_d),
    .det_i (det_d),
    .v_o   (out_valid),
    .res_o (out_data)
  );

  // A singular result carries zero entries and no saturation.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.out_r0c0 == 0 && out_data.out_r1c1 == 0 && out_data.out_r2c2 == 0 &&
      out_data.out_r0c1 == 0 && out_data.out_r1c2 == 0 && out_data.out_r2c0 == 0 &&
      out_data.out_r0c2 == 0 && out_data.out_r1c0 == 0 && out_data.out_r2c1 == 0 &&
      !out_data.saturated)
    else $error("singular result with nonzero entries");

  // Input back-pressure only comes from a held result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // A held result is still offered in the next cycle.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("held result dropped");

endmodule
